FILE: rtl/lpht_pkg.sv
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared sizes, codes and types of the linear probing hash table.
// ----------------------------------------------------------------------------
package lpht_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 64;
  localparam int KEY_BITS    = 31;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int SIZE_W      = $clog2(TABLE_DEPTH + 1);

  // field widths fixed by the port definition
  localparam int CMD_W  = 2;
  localparam int CODE_W = 2;
  localparam int CFG_W  = 7;
  localparam int SLOT_W = 6;

  localparam logic [CFG_W-1:0] CFG_SIZE_RESET = 7'd64;

  // remainder unit: bits of the key retired per cycle
  localparam int MOD_BITS_PER_STEP = 4;
  localparam int MOD_STEPS = (KEY_BITS + MOD_BITS_PER_STEP - 1) / MOD_BITS_PER_STEP;
  localparam int MOD_PAD_W = MOD_STEPS * MOD_BITS_PER_STEP;
  localparam int MOD_CNT_W = $clog2(MOD_STEPS);

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_FIND   = 2'd2
  } cmd_e;

  typedef enum logic [CODE_W-1:0] {
    RC_OK        = 2'd0,
    RC_NOT_FOUND = 2'd1,
    RC_FULL      = 2'd2
  } rc_e;

  typedef enum logic [1:0] {
    SLOT_EMPTY    = 2'd0,
    SLOT_OCCUPIED = 2'd1,
    SLOT_DELETED  = 2'd2
  } slot_status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_PROBE,
    ST_CHECK,
    ST_DONE
  } fsm_state_e;

  typedef struct packed {
    slot_status_e          status;
    logic [KEY_BITS-1:0]   key;
  } slot_word_t;

  // request to the remainder unit
  typedef struct packed {
    logic                  start;
    logic [KEY_BITS-1:0]   dividend;
    logic [SIZE_W-1:0]     divisor;
  } mod_req_t;

  // answer of the remainder unit
  typedef struct packed {
    logic                  done;
    logic [IDX_W-1:0]      rem;
  } mod_rsp_t;

  // zero counts as one slot, anything beyond the store saturates
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [CFG_W-1:0] v);
    logic [SIZE_W-1:0] s;
    if (v == '0) begin
      s = SIZE_W'(1);
    end else if (int'(v) > TABLE_DEPTH) begin
      s = SIZE_W'(TABLE_DEPTH);
    end else begin
      s = SIZE_W'(v);
    end
    return s;
  endfunction

endpackage

FILE: rtl/lpht_if.sv
// ----------------------------------------------------------------------------
// lpht channel interfaces
// Valid/ready channels for commands, results and the size register.
// ----------------------------------------------------------------------------
interface lpht_in_if;
  import lpht_pkg::*;
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [KEY_BITS-1:0] key;
  modport source (output valid, output cmd, output key, input ready);
  modport sink   (input valid, input cmd, input key, output ready);
endinterface

interface lpht_out_if;
  import lpht_pkg::*;
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] result_code;
  logic [SLOT_W-1:0] slot_index;
  modport source (output valid, output result_code, output slot_index, input ready);
  modport sink   (input valid, input result_code, input slot_index, output ready);
endinterface

interface lpht_cfg_if;
  import lpht_pkg::*;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/lpht_mod.sv
// ----------------------------------------------------------------------------
// lpht_mod
// Key modulo table size by restoring remainder, a few key bits per cycle.
// ----------------------------------------------------------------------------
module lpht_mod (
  input  logic              clk,
  input  logic              rst_n,
  input  lpht_pkg::mod_req_t req,
  output lpht_pkg::mod_rsp_t rsp
);
  import lpht_pkg::*;

  logic [MOD_PAD_W-1:0] shr_r, shr_nxt;
  logic [IDX_W-1:0]     rem_r, rem_nxt;
  logic [SIZE_W-1:0]    div_r;
  logic [MOD_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [IDX_W:0]       trial;
  logic [IDX_W-1:0]     part;

  // one group of remainder steps, most significant key bit first
  always_comb begin
    part = rem_r;
    trial = '0;
    for (int i = 0; i < MOD_BITS_PER_STEP; i++) begin
      trial = {part, shr_r[MOD_PAD_W-1-i]};
      if (trial >= (IDX_W+1)'(div_r)) begin
        trial = trial - (IDX_W+1)'(div_r);
      end
      part = trial[IDX_W-1:0];
    end
    rem_nxt = part;
    shr_nxt = shr_r << MOD_BITS_PER_STEP;
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == MOD_CNT_W'(MOD_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      shr_r <= MOD_PAD_W'(req.dividend);
      rem_r <= '0;
      div_r <= req.divisor;
    end else if (busy_r) begin
      shr_r <= shr_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

FILE: rtl/linear_probe_hash_table.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open addressing hash table with linear probing over an on-chip slot store.
// ----------------------------------------------------------------------------
// Usage
//   in_req  : one request per handshake, cmd (insert, remove, find) and key.
//   out_res : one result per request, result_code and slot_index, in order.
//   cfg_wr  : writes table_size; only while no request is outstanding.
// Flow
//   A request goes from acceptance to result through the key modulo table
//   size (four key bits a cycle, then a handover) and a walk over P slots,
//   where P is the number of slots probed (1 up to table_size). Each probe
//   is a read state and a check state; the store has one read and one
//   write port. An unused command skips the modulo and the walk.
//   One request is in work at a time; a finished result sits in the output
//   register, so the next request is taken while the receiver has not yet
//   collected it.
// Reset
//   All slots read as empty right after reset (per-slot valid flags), the
//   size register returns to 64 and no result is pending.
// Stall
//   If the output register is still full when a request finishes, the block
//   holds that result and takes nothing new until the receiver takes one.
// ----------------------------------------------------------------------------
module linear_probe_hash_table (
  input  logic clk,
  input  logic rst_n,
  lpht_cfg_if.sink   cfg_wr,
  lpht_in_if.sink    in_req,
  lpht_out_if.source out_res
);
  import lpht_pkg::*;

  fsm_state_e state_r, state_nxt;

  logic [SIZE_W-1:0]   size_r;
  logic [CMD_W-1:0]    cmd_r, cmd_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [SIZE_W-1:0]   n_r, n_nxt;
  rc_e                 res_code_r, res_code_nxt;
  logic [IDX_W-1:0]    res_idx_r, res_idx_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [CODE_W-1:0]   out_code_r;
  logic [SLOT_W-1:0]   out_idx_r;

  logic                in_fire;
  logic                out_free;
  logic                out_load;
  logic                mem_we;
  slot_word_t          wr_word;
  logic                hit;
  logic                stop_empty;
  logic                last_probe;

  slot_word_t          mem [TABLE_DEPTH];
  slot_word_t          rd_word_r;
  logic [TABLE_DEPTH-1:0] entry_vld_r;
  logic                rd_vld_r;
  slot_status_e        rd_status;

  mod_req_t            mreq;
  mod_rsp_t            mrsp;

  lpht_mod u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .rsp   (mrsp)
  );

  assign cfg_wr.ready = 1'b1;
  assign in_fire  = in_req.valid && in_req.ready;
  assign out_free = !out_valid_r || out_res.ready;

  // size register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= clamp_size(CFG_SIZE_RESET);
    end else if (cfg_wr.valid) begin
      size_r <= clamp_size(cfg_wr.data);
    end
  end

  // slot store, one read and one write port, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[idx_r] <= wr_word;
    end
    rd_word_r <= mem[idx_r];
  end

  // slot valid flags stand in for clearing the store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_vld_r <= '0;
      rd_vld_r    <= 1'b0;
    end else begin
      if (mem_we) begin
        entry_vld_r[idx_r] <= 1'b1;
      end
      rd_vld_r <= entry_vld_r[idx_r];
    end
  end

  assign rd_status = rd_vld_r ? rd_word_r.status : SLOT_EMPTY;

  // probe decision for the slot just read
  always_comb begin
    last_probe = (SIZE_W'(n_r + 1'b1) == size_r);
    if (cmd_r == CMD_INSERT) begin
      hit        = (rd_status != SLOT_OCCUPIED);
      stop_empty = 1'b0;
    end else begin
      hit        = (rd_status == SLOT_OCCUPIED) && (rd_word_r.key == key_r);
      stop_empty = (rd_status == SLOT_EMPTY);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_req.cmd == CMD_INSERT || in_req.cmd == CMD_REMOVE ||
              in_req.cmd == CMD_FIND) begin
            state_nxt = ST_MOD;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_MOD: begin
        if (mrsp.done) begin
          state_nxt = ST_PROBE;
        end
      end
      ST_PROBE: state_nxt = ST_CHECK;
      ST_CHECK: begin
        if (hit || stop_empty || last_probe) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_PROBE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and datapath next values
  always_comb begin
    in_req.ready  = (state_r == ST_IDLE);
    mreq.start    = 1'b0;
    mreq.dividend = in_req.key;
    mreq.divisor  = size_r;
    mem_we        = 1'b0;
    wr_word       = rd_word_r;
    out_load      = 1'b0;
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    idx_nxt       = idx_r;
    n_nxt         = n_r;
    res_code_nxt  = res_code_r;
    res_idx_nxt   = res_idx_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          mreq.start   = 1'b1;
          cmd_nxt      = in_req.cmd;
          key_nxt      = in_req.key;
          res_code_nxt = RC_NOT_FOUND;
          res_idx_nxt  = '0;
        end
      end
      ST_MOD: begin
        if (mrsp.done) begin
          idx_nxt = mrsp.rem;
          n_nxt   = '0;
        end
      end
      ST_PROBE: begin
      end
      ST_CHECK: begin
        if (hit) begin
          res_code_nxt = RC_OK;
          res_idx_nxt  = idx_r;
          if (cmd_r == CMD_INSERT) begin
            mem_we         = 1'b1;
            wr_word.status = SLOT_OCCUPIED;
            wr_word.key    = key_r;
          end else if (cmd_r == CMD_REMOVE) begin
            mem_we         = 1'b1;
            wr_word.status = SLOT_DELETED;
            wr_word.key    = rd_word_r.key;
          end
        end else if (stop_empty || last_probe) begin
          res_code_nxt = (cmd_r == CMD_INSERT) ? RC_FULL : RC_NOT_FOUND;
          res_idx_nxt  = '0;
        end else begin
          n_nxt = SIZE_W'(n_r + 1'b1);
          if ((SIZE_W'(idx_r) + 1'b1) == size_r) begin
            idx_nxt = '0;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      ST_DONE: begin
        out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  // result register valid
  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_res.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    key_r      <= key_nxt;
    idx_r      <= idx_nxt;
    n_r        <= n_nxt;
    res_code_r <= res_code_nxt;
    res_idx_r  <= res_idx_nxt;
    if (out_load) begin
      out_code_r <= res_code_r;
      out_idx_r  <= SLOT_W'(res_idx_r);
    end
  end

  assign out_res.valid       = out_valid_r;
  assign out_res.result_code = out_code_r;
  assign out_res.slot_index  = out_idx_r;

endmodule

FILE: verif/tb_linear_probe_hash_table.sv
// ----------------------------------------------------------------------------
// tb_linear_probe_hash_table
// Self-checking bench for the linear probing hash table. A short table of
// directed requests covers reset state, key extremes, wraparound, deleted
// slots, duplicates, full table, size zero and oversize, and the unused
// command. Random phases follow, each at its own table size and with a small
// pool of colliding keys. Each result is checked against a local model of the
// slot store or a typed row's value. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_linear_probe_hash_table;
  import lpht_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int DRAIN_CYCLES = 150;
  localparam int NUM_PHASES   = 10;
  localparam int PHASE_ITEMS  = 200;
  localparam int POOL_SIZE    = 16;
  localparam int NUM_DIRECTED = 24;

  typedef struct {
    logic [CODE_W-1:0] code;
    logic [SLOT_W-1:0] slot;
  } probe_result_t;

  typedef struct {
    logic [CFG_W-1:0]    size;
    logic [CMD_W-1:0]    cmd;
    logic [KEY_BITS-1:0] key;
    bit                  typed;
    logic [CODE_W-1:0]   code;
    logic [SLOT_W-1:0]   slot;
  } directed_row_t;

  logic clk;
  logic rst_n;

  lpht_cfg_if cfg_if ();
  lpht_in_if  in_if ();
  lpht_out_if out_if ();

  linear_probe_hash_table u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_wr  (cfg_if),
    .in_req  (in_if),
    .out_res (out_if)
  );

  // local copy of the slot store and the size register
  logic [KEY_BITS-1:0] stored_key [TABLE_DEPTH];
  slot_status_e        slot_state [TABLE_DEPTH];
  logic [CFG_W-1:0]    size_setting;

  probe_result_t       pending_results [$];
  logic [KEY_BITS-1:0] key_pool [POOL_SIZE];
  bit                  no_idle;
  int                  error_count;
  int                  cycle_count;

  // directed requests; typed rows carry their own expected result
  directed_row_t directed_rows [NUM_DIRECTED] = '{
    '{7'd64,  CMD_FIND,   31'd5,          1'b1, RC_NOT_FOUND, 6'd0},
    '{7'd64,  CMD_REMOVE, 31'd5,          1'b1, RC_NOT_FOUND, 6'd0},
    '{7'd64,  CMD_INSERT, 31'd0,          1'b1, RC_OK,        6'd0},
    '{7'd64,  CMD_INSERT, 31'h7fff_ffff,  1'b1, RC_OK,        6'd63},
    '{7'd64,  CMD_FIND,   31'h7fff_ffff,  1'b1, RC_OK,        6'd63},
    '{7'd64,  CMD_INSERT, 31'd64,         1'b0, RC_OK,        6'd0},
    '{7'd64,  CMD_INSERT, 31'd127,        1'b0, RC_OK,        6'd0},
    '{7'd64,  CMD_REMOVE, 31'd64,         1'b0, RC_OK,        6'd0},
    '{7'd64,  CMD_FIND,   31'd127,        1'b0, RC_OK,        6'd0},
    '{7'd64,  CMD_INSERT, 31'd128,        1'b0, RC_OK,        6'd0},
    '{7'd64,  CMD_INSERT, 31'd0,          1'b0, RC_OK,        6'd0},
    '{7'd64,  CMD_REMOVE, 31'd0,          1'b0, RC_OK,        6'd0},
    '{7'd64,  CMD_FIND,   31'd0,          1'b0, RC_OK,        6'd0},
    '{7'd64,  CMD_UNUSED, 31'd0,          1'b1, RC_NOT_FOUND, 6'd0},
    '{7'd64,  CMD_FIND,   31'd999,        1'b1, RC_NOT_FOUND, 6'd0},
    '{7'd2,   CMD_INSERT, 31'd5,          1'b0, RC_OK,        6'd0},
    '{7'd2,   CMD_INSERT, 31'd9,          1'b1, RC_FULL,      6'd0},
    '{7'd2,   CMD_FIND,   31'd64,         1'b1, RC_NOT_FOUND, 6'd0},
    '{7'd0,   CMD_INSERT, 31'd1,          1'b1, RC_FULL,      6'd0},
    '{7'd0,   CMD_FIND,   31'd5,          1'b1, RC_OK,        6'd0},
    '{7'd127, CMD_FIND,   31'd127,        1'b0, RC_OK,        6'd0},
    '{7'd127, CMD_REMOVE, 31'h7fff_ffff,  1'b1, RC_OK,        6'd63},
    '{7'd65,  CMD_INSERT, 31'h7fff_ffff,  1'b0, RC_OK,        6'd0},
    '{7'd3,   CMD_FIND,   31'd0,          1'b0, RC_OK,        6'd0}
  };

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // slots in use: zero counts as one, oversize saturates
  function automatic int slots_in_use(input logic [CFG_W-1:0] v);
    int s;
    s = int'(v);
    if (s == 0) s = 1;
    if (s > TABLE_DEPTH) s = TABLE_DEPTH;
    return s;
  endfunction

  // walk the local store exactly as the block should and update it
  function automatic probe_result_t probe_table(input logic [CMD_W-1:0] cmd,
                                                input logic [KEY_BITS-1:0] key);
    int            span;
    int            pos;
    int            n;
    probe_result_t res;
    span = slots_in_use(size_setting);
    pos  = int'(longint'(key) % longint'(span));
    res  = '{code: RC_NOT_FOUND, slot: '0};
    if (cmd == CMD_INSERT) begin
      for (n = 0; n < span; n++) begin
        if (slot_state[pos] != SLOT_OCCUPIED) begin
          stored_key[pos] = key;
          slot_state[pos] = SLOT_OCCUPIED;
          res = '{code: RC_OK, slot: SLOT_W'(pos)};
          return res;
        end
        pos = (pos + 1 == span) ? 0 : pos + 1;
      end
      res.code = RC_FULL;
    end else if (cmd == CMD_REMOVE || cmd == CMD_FIND) begin
      for (n = 0; n < span; n++) begin
        if (slot_state[pos] == SLOT_EMPTY) return res;
        if (slot_state[pos] == SLOT_OCCUPIED && stored_key[pos] == key) begin
          if (cmd == CMD_REMOVE) slot_state[pos] = SLOT_DELETED;
          res = '{code: RC_OK, slot: SLOT_W'(pos)};
          return res;
        end
        pos = (pos + 1 == span) ? 0 : pos + 1;
      end
    end
    return res;
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [CMD_W-1:0] pick_cmd();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return CMD_INSERT;
    if (r < 65) return CMD_REMOVE;
    if (r < 95) return CMD_FIND;
    return CMD_UNUSED;
  endfunction

  // keys clustered on a few home slots, the last slot among them, plus wide keys
  function automatic void fill_key_pool(input logic [CFG_W-1:0] v);
    int span;
    int home;
    span = slots_in_use(v);
    for (int j = 0; j < POOL_SIZE; j++) begin
      home = (j % 4 == 2) ? span - 1 : $urandom_range(0, span - 1);
      if (j % 4 == 3) begin
        key_pool[j] = KEY_BITS'($urandom);
      end else begin
        key_pool[j] = KEY_BITS'(home + span * $urandom_range(0, 1_000_000));
      end
    end
  endfunction

  function automatic logic [KEY_BITS-1:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    if (r < 90) return KEY_BITS'($urandom_range(0, 200));
    return KEY_BITS'($urandom);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // stop sending and let every outstanding request come back
  task automatic drain_requests();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_table_size(input logic [CFG_W-1:0] v);
    drain_requests();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= v;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    size_setting = v;
  endtask

  // one request; valid stays high on return so a back-to-back request follows
  task automatic send_request(input logic [CMD_W-1:0] cmd,
                              input logic [KEY_BITS-1:0] key,
                              input bit typed,
                              input probe_result_t typed_res);
    int            gap;
    probe_result_t res;
    gap = idle_len();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.cmd   <= cmd;
    in_if.key   <= key;
    do @(posedge clk); while (!in_if.ready);
    res = probe_table(cmd, key);
    if (typed) res = typed_res;
    pending_results.push_back(res);
  endtask

  // result side: check each accepted result, stall at random
  initial begin
    int            stall_left;
    probe_result_t exp_res;
    stall_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result code %0d slot %0d with no request outstanding",
                                    out_if.result_code, out_if.slot_index));
        end else begin
          exp_res = pending_results.pop_front();
          if (out_if.result_code !== exp_res.code)
            report_mismatch($sformatf("result_code %0d, expected %0d",
                                      out_if.result_code, exp_res.code));
          if (out_if.slot_index !== exp_res.slot)
            report_mismatch($sformatf("slot_index %0d, expected %0d",
                                      out_if.slot_index, exp_res.slot));
        end
      end
      if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else begin
        out_if.ready <= 1'b1;
        stall_left = idle_len();
      end
    end
  end

  // reset, directed table, random phases, end of run
  initial begin
    logic [CFG_W-1:0] phase_sizes [NUM_PHASES];
    probe_result_t    typed_res;
    probe_result_t    no_res;
    error_count  = 0;
    cycle_count  = 0;
    no_idle      = 1'b0;
    size_setting = CFG_SIZE_RESET;
    no_res       = '{code: RC_OK, slot: '0};
    for (int s = 0; s < TABLE_DEPTH; s++) begin
      stored_key[s] = '0;
      slot_state[s] = SLOT_EMPTY;
    end
    rst_n        <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.data  <= '0;
    in_if.valid  <= 1'b0;
    in_if.cmd    <= '0;
    in_if.key    <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, size changes only between drained requests
    foreach (directed_rows[i]) begin
      if (directed_rows[i].size != size_setting) write_table_size(directed_rows[i].size);
      typed_res = '{code: directed_rows[i].code, slot: directed_rows[i].slot};
      send_request(directed_rows[i].cmd, directed_rows[i].key,
                   directed_rows[i].typed, typed_res);
    end

    // random phases: extremes of the size register first, then arbitrary ones
    phase_sizes = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd65, 7'd2, 7'd0, 7'd33, 7'd0, 7'd64};
    phase_sizes[6] = CFG_W'($urandom_range(1, 63));
    phase_sizes[8] = CFG_W'($urandom_range(0, 127));
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_table_size(phase_sizes[p]);
      no_idle = ($urandom_range(0, 3) == 0);
      fill_key_pool(phase_sizes[p]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // halfway through, hold off until every result is back
        if (i == PHASE_ITEMS / 2) drain_requests();
        send_request(pick_cmd(), pick_key(), 1'b0, no_res);
      end
    end

    drain_requests();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/lpht_pkg.sv
rtl/lpht_if.sv
rtl/lpht_mod.sv
rtl/linear_probe_hash_table.sv
verif/tb_linear_probe_hash_table.sv
